@@ rtl/core/msseq_pkg.sv @@
package msseq_pkg;

  localparam int MAX_ITEMS_DEF  = 16;
  localparam int TICK_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  // Reach of the 4-bit slot field and largest value of the 5-bit count field
  localparam int SLOT_SPAN = 16;
  localparam int COUNT_MAX = 31;

  localparam logic [31:0] REPORT_PERIOD_RST = 32'd1000;

  localparam logic [3:0] CMD_START   = 4'd0;
  localparam logic [3:0] CMD_STOP    = 4'd1;
  localparam logic [3:0] CMD_SUSPEND = 4'd2;
  localparam logic [3:0] CMD_RESUME  = 4'd3;
  localparam logic [3:0] CMD_SKIP    = 4'd4;
  localparam logic [3:0] CMD_TICK    = 4'd5;
  localparam logic [3:0] CMD_LOAD    = 4'd6;
  localparam logic [3:0] CMD_SET     = 4'd7;
  localparam logic [3:0] CMD_READ    = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_STOP,
    OP_SUSPEND,
    OP_RESUME,
    OP_SKIP,
    OP_TICK,
    OP_LOAD,
    OP_SET,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [31:0] timeout;
    logic        no_timeout;
    logic        until_done;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic        done;
    logic [3:0]  slot;
    entry_t      entry;
    logic [4:0]  count;
  } req_t;

endpackage

@@ rtl/core/mission_step_sequencer.sv @@
// Mission step sequencer: takes one command request per cycle on the slave stream, unless
// back-pressure holds it, and returns exactly one result per request on the master stream,
// in order. A request passes a decode register, a two-entry queue and the executing stage
// with its output register. The execute stage updates mission state as it takes each
// request, so it sustains one request per cycle while the master stream does not stall.
// The item table is not cleared by reset: an item slot must be loaded before the mission
// reaches it. The report period must be written through the register port only while no
// request is in flight; the block itself does not enforce this.
module mission_step_sequencer #(
  parameter int MAX_ITEMS  = msseq_pkg::MAX_ITEMS_DEF,
  parameter int TICK_WIDTH = msseq_pkg::TICK_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action_done, item_slot, item_kind, item_target_id, item_timeout_ticks,
  // item_no_timeout, item_until_done, item count, zero pad
  input  logic [63:0] s_tdata,
  // cmd
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // activate_valid, activate_kind, activate_target, status, progress, length,
  // report_pending
  output logic [31:0] m_tdata,
  // report_valid
  output logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_REPORT_PERIOD = 1'b0;

  logic [31:0]     report_period;
  logic            f_valid;
  logic            f_ready;
  msseq_pkg::req_t f_req;
  logic            q_valid;
  logic            q_ready;
  msseq_pkg::req_t q_req;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REPORT_PERIOD) ? report_period : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period <= msseq_pkg::REPORT_PERIOD_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_REPORT_PERIOD) begin
      report_period <= pwdata;
    end
  end

  msseq_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .req_valid (f_valid),
    .req_ready (f_ready),
    .req       (f_req)
  );

  msseq_queue #(
    .DEPTH (msseq_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_req),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_req)
  );

  msseq_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (q_valid),
    .req_ready     (q_ready),
    .req           (q_req),
    .report_period (report_period),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule

@@ rtl/core/msseq_front.sv @@
module msseq_front #(
  parameter int MAX_ITEMS = msseq_pkg::MAX_ITEMS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,
  input  logic [3:0]       s_tuser,
  output logic             req_valid,
  input  logic             req_ready,
  output msseq_pkg::req_t  req
);

  msseq_pkg::req_t dec;
  logic [4:0]      items;

  assign s_tready = !req_valid || req_ready;
  assign items    = s_tdata[61:57];

  always_comb begin
    dec.op               = msseq_pkg::OP_NOP;
    dec.done             = s_tdata[0];
    dec.slot             = s_tdata[4:1];
    dec.entry.kind       = s_tdata[6:5];
    dec.entry.target     = s_tdata[22:7];
    dec.entry.timeout    = s_tdata[54:23];
    dec.entry.no_timeout = s_tdata[55];
    dec.entry.until_done = s_tdata[56];
    if (int'(items) > MAX_ITEMS) begin
      dec.count = 5'(MAX_ITEMS);
    end else begin
      dec.count = items;
    end
    case (s_tuser)
      msseq_pkg::CMD_START:   dec.op = msseq_pkg::OP_START;
      msseq_pkg::CMD_STOP:    dec.op = msseq_pkg::OP_STOP;
      msseq_pkg::CMD_SUSPEND: dec.op = msseq_pkg::OP_SUSPEND;
      msseq_pkg::CMD_RESUME:  dec.op = msseq_pkg::OP_RESUME;
      msseq_pkg::CMD_SKIP:    dec.op = msseq_pkg::OP_SKIP;
      msseq_pkg::CMD_TICK:    dec.op = msseq_pkg::OP_TICK;
      msseq_pkg::CMD_LOAD: begin
        if (int'(dec.slot) < MAX_ITEMS) dec.op = msseq_pkg::OP_LOAD;
      end
      msseq_pkg::CMD_SET: begin
        if (items != 5'd0) dec.op = msseq_pkg::OP_SET;
      end
      msseq_pkg::CMD_READ:    dec.op = msseq_pkg::OP_READ;
      default:                dec.op = msseq_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req <= dec;
    end
  end

endmodule

@@ rtl/core/msseq_queue.sv @@
module msseq_queue #(
  parameter int DEPTH = msseq_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  msseq_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output msseq_pkg::req_t  out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  msseq_pkg::req_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   cnt;
  logic            push;
  logic            pop;

  assign in_ready  = cnt != CW'(DEPTH);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

@@ rtl/core/msseq_back.sv @@
module msseq_back #(
  parameter int MAX_ITEMS  = msseq_pkg::MAX_ITEMS_DEF,
  parameter int TICK_WIDTH = msseq_pkg::TICK_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  msseq_pkg::req_t  req,
  input  logic [31:0]      report_period,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,
  output logic [0:0]       m_tuser
);

  localparam int CNT_MAX   = (MAX_ITEMS < msseq_pkg::COUNT_MAX) ?
                             MAX_ITEMS : msseq_pkg::COUNT_MAX;
  localparam int TBL_DEPTH = (MAX_ITEMS < msseq_pkg::SLOT_SPAN) ?
                             MAX_ITEMS : msseq_pkg::SLOT_SPAN;
  localparam int IW        = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CMP_W     = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    MODE_DISABLED  = 2'd0,
    MODE_ENABLED   = 2'd1,
    MODE_SUSPENDED = 2'd2
  } mode_t;

  mode_t                    mode, mode_next;
  logic [IW-1:0]            item_index, item_index_next;
  logic [4:0]               mission_count, mission_count_next;
  msseq_pkg::entry_t        item_table [TBL_DEPTH];
  msseq_pkg::entry_t        cur, cur_next;
  logic [TICK_WIDTH-1:0]    item_elapsed, item_elapsed_next;
  logic [TICK_WIDTH-1:0]    since_report, since_report_next;
  logic                     report_flag, report_flag_next;

  logic                     fire;
  logic [IW-1:0]            rd_idx;
  logic [4:0]               next_pos;
  msseq_pkg::entry_t        rd_entry;
  logic                     act;
  logic                     rep;
  logic [4:0]               progress_next;

  assign req_ready = !m_tvalid || m_tready;
  assign fire      = req_valid && req_ready;
  assign rd_idx    = (mode == MODE_ENABLED) ? item_index + IW'(1) : item_index;
  assign next_pos  = 5'(item_index) + 5'd1;
  assign rd_entry  = (int'(rd_idx) < TBL_DEPTH) ? item_table[rd_idx[AW-1:0]] : '0;

  always_comb begin
    logic [TICK_WIDTH-1:0] since_inc;
    logic [TICK_WIDTH-1:0] el_inc;
    logic                  advance;
    logic                  begin_it;
    logic                  complete;

    mode_next          = mode;
    item_index_next    = item_index;
    mission_count_next = mission_count;
    cur_next           = cur;
    item_elapsed_next  = item_elapsed;
    since_report_next  = since_report;
    report_flag_next   = report_flag;
    act                = 1'b0;
    rep                = 1'b0;
    advance            = 1'b0;
    begin_it           = 1'b0;
    complete           = 1'b0;
    since_inc          = (since_report == TICK_MAX) ? since_report
                                                    : since_report + TICK_WIDTH'(1);
    el_inc             = (item_elapsed == TICK_MAX) ? item_elapsed
                                                    : item_elapsed + TICK_WIDTH'(1);

    case (req.op)
      msseq_pkg::OP_START: begin
        report_flag_next = 1'b1;
        if (mode == MODE_DISABLED && mission_count != 5'd0) begin
          mode_next = MODE_ENABLED;
          begin_it  = 1'b1;
        end
      end
      msseq_pkg::OP_STOP: begin
        report_flag_next = 1'b1;
        mode_next        = MODE_DISABLED;
        item_index_next  = '0;
      end
      msseq_pkg::OP_SUSPEND: begin
        report_flag_next = 1'b1;
        if (mode == MODE_ENABLED) mode_next = MODE_SUSPENDED;
      end
      msseq_pkg::OP_RESUME: begin
        report_flag_next = 1'b1;
        if (mode == MODE_SUSPENDED) mode_next = MODE_ENABLED;
      end
      msseq_pkg::OP_SKIP: begin
        report_flag_next = 1'b1;
        if (mode == MODE_ENABLED) advance = 1'b1;
      end
      msseq_pkg::OP_TICK: begin
        since_report_next = since_inc;
        if (CMP_W'(since_inc) >= CMP_W'(report_period)) report_flag_next = 1'b1;
        if (mode == MODE_ENABLED) begin
          item_elapsed_next = el_inc;
          if (cur.until_done) begin
            complete = req.done;
          end else begin
            complete = !cur.no_timeout && (CMP_W'(el_inc) >= CMP_W'(cur.timeout));
          end
          advance = complete;
        end
      end
      msseq_pkg::OP_LOAD: begin
        if (int'(req.slot) == int'(item_index)) cur_next = req.entry;
      end
      msseq_pkg::OP_SET: begin
        mission_count_next = req.count;
        mode_next          = MODE_DISABLED;
        item_index_next    = '0;
        report_flag_next   = 1'b1;
      end
      msseq_pkg::OP_READ: begin
        report_flag_next  = 1'b0;
        since_report_next = '0;
        rep               = 1'b1;
      end
      default: begin
      end
    endcase

    if (advance) begin
      if (next_pos >= mission_count) begin
        mode_next        = MODE_DISABLED;
        item_index_next  = '0;
        report_flag_next = 1'b1;
      end else begin
        item_index_next = rd_idx;
        begin_it        = 1'b1;
      end
    end

    if (begin_it) begin
      item_elapsed_next = '0;
      report_flag_next  = 1'b1;
      act               = 1'b1;
      cur_next          = rd_entry;
    end

    progress_next = (mission_count_next != 5'd0) ? 5'(item_index_next) + 5'd1 : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_DISABLED;
      item_index    <= '0;
      mission_count <= '0;
      item_elapsed  <= '0;
      since_report  <= '0;
      report_flag   <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (fire) begin
        mode          <= mode_next;
        item_index    <= item_index_next;
        mission_count <= mission_count_next;
        item_elapsed  <= item_elapsed_next;
        since_report  <= since_report_next;
        report_flag   <= report_flag_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur <= cur_next;
      if (req.op == msseq_pkg::OP_LOAD) begin
        item_table[req.slot[AW-1:0]] <= req.entry;
      end
      m_tdata <= {report_flag_next, mission_count_next, progress_next, mode_next,
                  act ? rd_entry.target : 16'd0, act ? rd_entry.kind : 2'd0, act};
      m_tuser <= rep;
    end
  end

endmodule
